// ===== src/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Fixed-point format, operator codes, state encodings and unit interfaces.
// ----------------------------------------------------------------------------
package iee_pkg;

   // Fixed-point format
   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 48;
   localparam int OPERAND_W   = 31;

   // Derived widths
   localparam int LIT_W  = OPERAND_W + FRAC_BITS;
   localparam int CMP_W  = (LIT_W > VALUE_WIDTH) ? LIT_W : VALUE_WIDTH;
   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int NUM_W  = VALUE_WIDTH + FRAC_BITS;
   localparam int MAG_W  = ((PROD_W - FRAC_BITS) > NUM_W) ? (PROD_W - FRAC_BITS) : NUM_W;
   localparam int ADD_W  = VALUE_WIDTH + 2;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam logic [VALUE_WIDTH-1:0] MAX_MAG = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Operator codes
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Evaluator sequencer
   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_WAIT
   } eval_state_type;

   // Arithmetic unit sequencer
   typedef enum logic [2:0] {
      U_IDLE,
      U_ADD,
      U_MUL,
      U_DIV,
      U_FIX,
      U_DONE
   } alu_state_type;

   // Command into the arithmetic unit
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

   // Result out of the arithmetic unit
   typedef struct packed {
      value_type value;
      logic      div0;
      logic      ovf;
   } alu_res_type;

   // Multiply and divide bind tighter than add and subtract
   function automatic logic op_level(op_type op);
      return (op == OP_MUL) || (op == OP_DIV);
   endfunction

endpackage

// ===== src/iee_req_if.sv =====
// ----------------------------------------------------------------------------
// iee_req_if: token channel into the evaluator
// One item is one operand literal with the operator that follows it.
// ----------------------------------------------------------------------------
interface iee_req_if;
   logic                         valid;
   logic                         ready;
   logic [iee_pkg::OPERAND_W-1:0] operand;
   iee_pkg::op_type              next_operator;
   logic                         last;

   modport source (output valid, operand, next_operator, last, input ready);
   modport sink (input valid, operand, next_operator, last, output ready);
endinterface

// ===== src/iee_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iee_rsp_if: result channel out of the evaluator
// One item per expression: fixed-point value plus sticky error flags.
// ----------------------------------------------------------------------------
interface iee_rsp_if;
   logic                valid;
   logic                ready;
   iee_pkg::value_type  value;
   logic                divide_by_zero;
   logic                overflow;

   modport source (output valid, value, divide_by_zero, overflow, input ready);
   modport sink (input valid, value, divide_by_zero, overflow, output ready);
endinterface

// ===== src/iee_alu.sv =====
// ----------------------------------------------------------------------------
// iee_alu: iterative fixed-point arithmetic unit
// One shared adder serves add/sub in one pass, multiply by shift-and-add
// (one bit per cycle) and divide by restoring division (one quotient bit
// per cycle), then a fix-up pass that saturates and applies the sign.
// ----------------------------------------------------------------------------
module iee_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  iee_pkg::alu_cmd_type cmd,
   input  iee_pkg::value_type   a_value,
   input  iee_pkg::value_type   b_value,
   output logic                 done,
   output iee_pkg::alu_res_type result
);
   import iee_pkg::*;

   alu_state_type              state_ff, state_in;
   op_type                     op_ff, op_in;
   logic                       neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]     xa_ff, xa_in;
   logic [VALUE_WIDTH-1:0]     xb_ff, xb_in;
   logic [VALUE_WIDTH:0]       acc_ff, acc_in;
   logic [NUM_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   alu_res_type                res_ff, res_in;

   logic [VALUE_WIDTH-1:0]     a_mag, b_mag;
   logic [ADD_W-1:0]           add_x, add_y, add_sum;
   logic                       add_inv;
   logic [VALUE_WIDTH-1:0]     rem_sh;
   logic                       fits;
   logic [PROD_W-1:0]          prod;
   logic [MAG_W-1:0]           mag, lim;
   logic                       add_ovf, fix_ovf;

   // Operand magnitudes at start
   assign a_mag = a_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~a_value + 1'b1) : a_value;
   assign b_mag = b_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~b_value + 1'b1) : b_value;

   // Partial remainder with next numerator bit; product and final magnitude
   assign rem_sh = {acc_ff[VALUE_WIDTH-2:0], lo_ff[NUM_W-1]};
   assign prod   = {acc_ff[VALUE_WIDTH-1:0], lo_ff[VALUE_WIDTH-1:0]};
   assign mag    = (op_ff == OP_MUL) ? MAG_W'(prod >> FRAC_BITS) : MAG_W'(lo_ff);
   assign lim    = MAG_W'(MAX_MAG) + MAG_W'(neg_ff);

   // Shared adder operand selection
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_inv = 1'b0;
      case (state_ff)
         U_ADD: begin
            add_x   = {{2{xa_ff[VALUE_WIDTH-1]}}, xa_ff};
            add_y   = {{2{xb_ff[VALUE_WIDTH-1]}}, xb_ff};
            add_inv = (op_ff == OP_SUB);
         end
         U_MUL: begin
            add_x = ADD_W'(acc_ff);
            add_y = lo_ff[0] ? ADD_W'(xa_ff) : '0;
         end
         U_DIV: begin
            add_x   = ADD_W'(rem_sh);
            add_y   = ADD_W'(xb_ff);
            add_inv = 1'b1;
         end
         U_FIX: begin
            add_y   = ADD_W'(mag[VALUE_WIDTH-1:0]);
            add_inv = neg_ff;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   assign add_sum = add_x + (add_y ^ {ADD_W{add_inv}}) + ADD_W'(add_inv);
   assign fits    = ~add_sum[ADD_W-1];
   assign add_ovf = ~((&add_sum[ADD_W-1:VALUE_WIDTH-1]) | ~(|add_sum[ADD_W-1:VALUE_WIDTH-1]));
   assign fix_ovf = (mag > lim);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_ADD, OP_SUB: state_in = U_ADD;
                  OP_MUL:         state_in = U_MUL;
                  default:        state_in = (b_value == '0) ? U_DONE : U_DIV;
               endcase
            end
         end
         U_ADD:   state_in = U_DONE;
         U_MUL, U_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = U_FIX;
         end
         U_FIX:   state_in = U_DONE;
         U_DONE:  state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in  = op_ff;
      neg_in = neg_ff;
      xa_in  = xa_ff;
      xb_in  = xb_ff;
      acc_in = acc_ff;
      lo_in  = lo_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               neg_in = a_value[VALUE_WIDTH-1] ^ b_value[VALUE_WIDTH-1];
               acc_in = '0;
               case (cmd.op)
                  OP_ADD, OP_SUB: begin
                     xa_in = a_value;
                     xb_in = b_value;
                  end
                  OP_MUL: begin
                     xa_in  = a_mag;
                     lo_in  = NUM_W'(b_mag);
                     cnt_in = CNT_W'(VALUE_WIDTH);
                  end
                  default: begin
                     xb_in  = b_mag;
                     lo_in  = NUM_W'(a_mag) << FRAC_BITS;
                     cnt_in = CNT_W'(NUM_W);
                     // zero divisor saturates toward the dividend's sign
                     res_in.value = a_value[VALUE_WIDTH-1] ? MIN_VAL : MAX_VAL;
                     res_in.div0  = 1'b1;
                     res_in.ovf   = 1'b0;
                  end
               endcase
            end
         end
         U_ADD: begin
            res_in.div0  = 1'b0;
            res_in.ovf   = add_ovf;
            res_in.value = add_ovf ? (add_sum[ADD_W-1] ? MIN_VAL : MAX_VAL)
                                   : value_type'(add_sum[VALUE_WIDTH-1:0]);
         end
         U_MUL: begin
            // shift the partial product right by one with the new sum bit
            acc_in = (VALUE_WIDTH+1)'(add_sum >> 1);
            lo_in  = NUM_W'({add_sum[0], lo_ff[VALUE_WIDTH-1:1]});
            cnt_in = cnt_ff - 1'b1;
         end
         U_DIV: begin
            acc_in = fits ? (VALUE_WIDTH+1)'(add_sum) : (VALUE_WIDTH+1)'(rem_sh);
            lo_in  = {lo_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end
         U_FIX: begin
            res_in.div0  = 1'b0;
            res_in.ovf   = fix_ovf;
            res_in.value = fix_ovf ? (neg_ff ? MIN_VAL : MAX_VAL)
                                   : value_type'(add_sum[VALUE_WIDTH-1:0]);
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Outputs
   always_comb begin
      done   = (state_ff == U_DONE);
      result = res_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      neg_ff <= neg_in;
      xa_ff  <= xa_in;
      xb_ff  <= xb_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

endmodule

// ===== src/infix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core: two-stack infix expression evaluator
// Usage:
//   req_chan takes one item per token: an unsigned integer operand, the
//   operator after it (add, sub, mul, div) and last on the final operand.
//   rsp_chan gives one item per expression, only after the last token:
//   signed fixed-point value (16 fraction bits) and sticky divide-by-zero
//   and overflow flags. Mul/div bind tighter than add/sub; equal levels
//   bind left to right. Results saturate.
// Flow:
//   An item is taken and checked, then runs its reductions (at most two
//   per item) in the shared arithmetic unit: add/sub in U_ADD, multiply
//   in U_MUL then U_FIX, divide in U_DIV then U_FIX, a zero divisor to
//   U_DONE directly. req_chan.ready is low while an item is in work.
// Reset and stalls:
//   Reset empties both stacks and clears the flags and the output valid bit.
//   The result sits in an output register; tokens keep flowing while it
//   waits, and only the next expression's last token stalls behind it.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core (
   input  logic         clock,
   input  logic         reset,
   iee_req_if.sink      req_chan,
   iee_rsp_if.source    rsp_chan
);
   import iee_pkg::*;

   localparam int FLAG_DIV0 = 0;
   localparam int FLAG_OVF  = 1;

   eval_state_type  state_ff, state_in;
   value_type       vs_ff [3];
   value_type       vs_in [3];
   logic [1:0]      vc_ff, vc_in;
   op_type          os_ff [2];
   op_type          os_in [2];
   logic [1:0]      oc_ff, oc_in;
   logic [1:0]      flags_ff, flags_in;
   op_type          cur_op_ff, cur_op_in;
   logic            cur_last_ff, cur_last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   value_type       rsp_value_ff, rsp_value_in;
   logic            rsp_div0_ff, rsp_div0_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic            accept;
   logic [CMP_W-1:0] lit_wide;
   logic            lit_sat;
   value_type       lit;
   logic            can_reduce, do_reduce, out_free;
   alu_cmd_type     alu_cmd;
   logic            alu_done;
   alu_res_type     alu_res;

   // Literal scaling with saturation
   assign lit_wide = CMP_W'(req_chan.operand) << FRAC_BITS;
   assign lit_sat  = (lit_wide > CMP_W'(MAX_MAG));
   assign lit      = lit_sat ? MAX_VAL : value_type'(lit_wide[VALUE_WIDTH-1:0]);

   assign accept     = req_chan.valid & req_chan.ready;
   assign can_reduce = (oc_ff != 2'd0) && (vc_ff >= 2'd2);
   assign do_reduce  = can_reduce &&
                       (cur_last_ff || (op_level(os_ff[0]) >= op_level(cur_op_ff)));
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;

   // Shared arithmetic unit; left operand is next-to-top, right is top
   iee_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .cmd     (alu_cmd),
      .a_value (vs_ff[1]),
      .b_value (vs_ff[0]),
      .done    (alu_done),
      .result  (alu_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (do_reduce)        state_in = S_WAIT;
            else if (!cur_last_ff) state_in = S_IDLE;
            else if (out_free)    state_in = S_IDLE;
         end
         S_WAIT: begin
            if (alu_done) state_in = S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_chan.ready         = (state_ff == S_IDLE);
      alu_cmd.start          = (state_ff == S_CHECK) && do_reduce;
      alu_cmd.op             = os_ff[0];
      rsp_chan.valid         = rsp_valid_ff;
      rsp_chan.value         = rsp_value_ff;
      rsp_chan.divide_by_zero = rsp_div0_ff;
      rsp_chan.overflow      = rsp_ovf_ff;
   end

   // Stacks, flags and output register next values
   always_comb begin
      vs_in        = vs_ff;
      vc_in        = vc_ff;
      os_in        = os_ff;
      oc_in        = oc_ff;
      flags_in     = flags_ff;
      cur_op_in    = cur_op_ff;
      cur_last_in  = cur_last_ff;
      rsp_value_in = rsp_value_ff;
      rsp_div0_in  = rsp_div0_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_op_in   = req_chan.next_operator;
               cur_last_in = req_chan.last;
               if (lit_sat) flags_in[FLAG_OVF] = 1'b1;
               // push onto the value stack, top at entry 0
               if (vc_ff != 2'd3) begin
                  vs_in[0] = lit;
                  vs_in[1] = vs_ff[0];
                  vs_in[2] = vs_ff[1];
                  vc_in    = vc_ff + 2'd1;
               end
            end
         end
         S_CHECK: begin
            if (!do_reduce) begin
               if (!cur_last_ff) begin
                  if (oc_ff != 2'd2) begin
                     os_in[0] = cur_op_ff;
                     os_in[1] = os_ff[0];
                     oc_in    = oc_ff + 2'd1;
                  end
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = (vc_ff != 2'd0) ? vs_ff[0] : '0;
                  rsp_div0_in  = flags_ff[FLAG_DIV0];
                  rsp_ovf_in   = flags_ff[FLAG_OVF];
                  vc_in        = 2'd0;
                  oc_in        = 2'd0;
                  flags_in     = 2'b00;
               end
            end
         end
         S_WAIT: begin
            if (alu_done) begin
               // pop two values and one operator, push the result
               vs_in[0] = alu_res.value;
               vs_in[1] = vs_ff[2];
               vc_in    = vc_ff - 2'd1;
               os_in[0] = os_ff[1];
               oc_in    = oc_ff - 2'd1;
               flags_in = flags_ff | {alu_res.ovf, alu_res.div0};
            end
         end
         default: begin
            vc_in = vc_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vc_ff        <= 2'd0;
         oc_ff        <= 2'd0;
         flags_ff     <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         oc_ff        <= oc_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      vs_ff        <= vs_in;
      os_ff        <= os_in;
      cur_op_ff    <= cur_op_in;
      cur_last_ff  <= cur_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_div0_ff  <= rsp_div0_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Checks
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_WAIT))
      else $error("arithmetic unit finished outside of a reduction");

   a_start_operands: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> ((vc_ff >= 2'd2) && (oc_ff != 2'd0)))
      else $error("reduction started without two values and one operator");

   a_balanced_stacks: assert property (@(posedge clock) disable iff (reset)
      accept |-> (vc_ff == oc_ff))
      else $error("value and operator stacks out of step between tokens");

endmodule
